@@ rtl/core/trimmed_mean_3x3_filter_unit_defines.svh @@
// Assertion macros used by the checker file.
`ifndef TRIMMED_MEAN_3X3_FILTER_UNIT_DEFINES_SVH
`define TRIMMED_MEAN_3X3_FILTER_UNIT_DEFINES_SVH

// Same-cycle implication on the rising edge of clk, off while in reset.
`define TMF_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tmf check failed");

// Next-cycle implication on the rising edge of clk, off while in reset.
`define TMF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tmf check failed");

`endif

@@ rtl/core/tmf_pkg.sv @@
package tmf_pkg;

    localparam int PIX_W      = 8;
    localparam int DIM_W      = 10;
    localparam int SUM_W      = 12;
    localparam int QUO_W      = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int MAX_HEIGHT = 512;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIM   = 2'd2;

    localparam int RECIP_SHIFT = 17;
    localparam int PROD_W      = SUM_W + 16;
    localparam logic [15:0] RECIP3 = 16'd43691;
    localparam logic [15:0] RECIP7 = 16'd18725;
    localparam logic [15:0] RECIP9 = 16'd14564;

    typedef logic [8:0][PIX_W-1:0] window_t;

    typedef struct packed {
        logic top;
        logic bottom;
        logic left;
        logic right;
    } border_flags_t;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [PIX_W-1:0] lo;
        logic [PIX_W-1:0] hi;
        logic             border;
        logic             corner;
        logic             last;
    } stats_t;

    function automatic logic [QUO_W-1:0] recip_div(input logic [SUM_W-1:0] x,
                                                   input logic [15:0] recip);
        logic [PROD_W-1:0] p;
        p = PROD_W'(x) * PROD_W'(recip);
        return p[RECIP_SHIFT +: QUO_W];
    endfunction

    function automatic logic [QUO_W-1:0] div3(input logic [SUM_W-1:0] x);
        return recip_div(x, RECIP3);
    endfunction

    function automatic logic [QUO_W-1:0] div7(input logic [SUM_W-1:0] x);
        return recip_div(x, RECIP7);
    endfunction

    function automatic logic [QUO_W-1:0] div9(input logic [SUM_W-1:0] x);
        return recip_div(x, RECIP9);
    endfunction

endpackage

@@ rtl/core/tmf_ram.sv @@
module tmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ rtl/core/tmf_window.sv @@
module tmf_window #(
    parameter int MAX_WIDTH = 512
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         rd_en,
    input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
    input  logic                         shift_en,
    input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
    input  logic [tmf_pkg::PIX_W-1:0]    pixel,
    output tmf_pkg::window_t             win
);

    import tmf_pkg::*;

    logic [PIX_W-1:0] up1;
    logic [PIX_W-1:0] up2;
    window_t          win_reg;

    tmf_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_a (
        .clk   (clk),
        .we    (shift_en),
        .waddr (wr_addr),
        .wdata (pixel),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (up1)
    );

    tmf_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_b (
        .clk   (clk),
        .we    (shift_en),
        .waddr (wr_addr),
        .wdata (up1),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (up2)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= '0;
        end
        else if (shift_en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                win_reg[k*3+0] <= win_reg[k*3+1];
                win_reg[k*3+1] <= win_reg[k*3+2];
            end
            win_reg[2] <= up2;
            win_reg[5] <= up1;
            win_reg[8] <= pixel;
        end
    end

    assign win = win_reg;

endmodule

@@ rtl/core/tmf_reduce.sv @@
module tmf_reduce (
    input  tmf_pkg::window_t       win,
    input  tmf_pkg::border_flags_t flags,
    input  logic                   last,
    output tmf_pkg::stats_t        stats
);

    import tmf_pkg::*;

    logic [SUM_W-1:0] sum;
    logic [PIX_W-1:0] lo;
    logic [PIX_W-1:0] hi;
    logic             use_px;

    always_comb
    begin
        sum = '0;
        lo  = '1;
        hi  = '0;
        for (int dr = 0; dr < 3; dr++)
        begin
            for (int dc = 0; dc < 3; dc++)
            begin
                use_px = !((dr == 0) && flags.top) && !((dr == 2) && flags.bottom) &&
                         !((dc == 0) && flags.left) && !((dc == 2) && flags.right);
                if (use_px)
                begin
                    sum = sum + SUM_W'(win[dr*3+dc]);
                    if (win[dr*3+dc] < lo)
                    begin
                        lo = win[dr*3+dc];
                    end
                    if (win[dr*3+dc] > hi)
                    begin
                        hi = win[dr*3+dc];
                    end
                end
            end
        end
    end

    assign stats.sum    = sum;
    assign stats.lo     = lo;
    assign stats.hi     = hi;
    assign stats.border = flags.top | flags.bottom | flags.left | flags.right;
    assign stats.corner = (flags.top | flags.bottom) & (flags.left | flags.right);
    assign stats.last   = last;

endmodule

@@ rtl/core/tmf_divider.sv @@
module tmf_divider (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      trimmed,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  tmf_pkg::stats_t           in_stats,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [tmf_pkg::PIX_W-1:0] out_pixel,
    output logic                      out_last
);

    import tmf_pkg::*;

    logic             a_valid_reg;
    stats_t           a_stats_reg;
    logic             b_valid_reg;
    logic [SUM_W-1:0] b_sum_reg;
    logic [PIX_W-1:0] b_mean_reg;
    logic [PIX_W-1:0] b_inner_reg;
    logic             b_border_reg;
    logic             b_corner_reg;
    logic             b_last_reg;
    logic             c_valid_reg;
    logic [PIX_W-1:0] c_pixel_reg;
    logic             c_last_reg;

    logic             a_ready;
    logic             b_ready;
    logic             c_ready;
    logic [PIX_W-1:0] mean_next;
    logic [PIX_W-1:0] inner_next;
    logic [SUM_W-1:0] trim_sum;
    logic [SUM_W-1:0] padded_sum;
    logic [SUM_W-1:0] mean_ext;
    logic [PIX_W-1:0] pixel_next;

    assign c_ready  = !c_valid_reg || out_ready;
    assign b_ready  = !b_valid_reg || c_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    // mean over the in-image neighbours: four at a corner, six along a side
    always_comb
    begin
        trim_sum = a_stats_reg.sum - SUM_W'(a_stats_reg.lo) - SUM_W'(a_stats_reg.hi);
        if (a_stats_reg.corner)
        begin
            mean_next = PIX_W'(a_stats_reg.sum >> 2);
        end
        else
        begin
            mean_next = PIX_W'(div3(a_stats_reg.sum >> 1));
        end
        if (trimmed)
        begin
            inner_next = PIX_W'(div7(trim_sum));
        end
        else
        begin
            inner_next = PIX_W'(div9(a_stats_reg.sum));
        end
    end

    // fill missing neighbours with the mean and divide by nine at the border
    always_comb
    begin
        mean_ext = SUM_W'(b_mean_reg);
        if (b_corner_reg)
        begin
            padded_sum = b_sum_reg + (mean_ext << 2) + mean_ext;
        end
        else
        begin
            padded_sum = b_sum_reg + (mean_ext << 1) + mean_ext;
        end
        if (b_border_reg)
        begin
            pixel_next = PIX_W'(div9(padded_sum));
        end
        else
        begin
            pixel_next = b_inner_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
            begin
                a_valid_reg <= in_valid;
            end
            if (b_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (c_ready)
            begin
                c_valid_reg <= b_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready)
        begin
            a_stats_reg <= in_stats;
        end
        if (b_ready)
        begin
            b_sum_reg    <= a_stats_reg.sum;
            b_mean_reg   <= mean_next;
            b_inner_reg  <= inner_next;
            b_border_reg <= a_stats_reg.border;
            b_corner_reg <= a_stats_reg.corner;
            b_last_reg   <= a_stats_reg.last;
        end
        if (c_ready)
        begin
            c_pixel_reg <= pixel_next;
            c_last_reg  <= b_last_reg;
        end
    end

    assign out_valid = c_valid_reg;
    assign out_pixel = c_pixel_reg;
    assign out_last  = c_last_reg;

endmodule

@@ rtl/core/trimmed_mean_3x3_filter_unit.sv @@
// Path: the word that completes a window passes s1, the window and s2, then divider
// stages a, b, c; that word arrives one row plus one pixel after the centre pixel.
// Throughput: one word in and one result out per cycle when not stalled; each line
// buffer is read once and written once per word, on separate read and write ports.
// Reset: counters, window and handshake state clear at once; line buffer contents
// are unknown until written, registers return to width 512, height 512, trimming on.
module trimmed_mean_3x3_filter_unit #(
    parameter int MAX_WIDTH = 512
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [7:0] pixel_in
    input  logic [0:0]                    s_tuser,   // [0] is_pad
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata,   // [7:0] pixel_out
    output logic                          m_tlast,
    input  logic                          cfg_we,
    input  logic [tmf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tmf_pkg::DIM_W-1:0]     cfg_data
);

    import tmf_pkg::*;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int WMAX_W = $clog2(MAX_WIDTH + 1);
    localparam int WEFF_W = (WMAX_W > DIM_W) ? WMAX_W : DIM_W;

    logic [DIM_W-1:0]  width_reg;
    logic [DIM_W-1:0]  height_reg;
    logic              trim_reg;
    logic [DIM_W-1:0]  row_reg;
    logic [DIM_W-1:0]  row_next;
    logic [COL_W-1:0]  col_reg;
    logic [COL_W-1:0]  col_next;

    logic [WEFF_W-1:0] w_eff;
    logic [DIM_W-1:0]  h_eff;
    logic [DIM_W-1:0]  cen_row;
    logic [COL_W-1:0]  cen_col;
    logic              have;
    logic              last;
    border_flags_t     flags;
    logic [PIX_W-1:0]  pixel;
    logic              cfg_hit;

    logic              s1_valid_reg;
    logic [PIX_W-1:0]  s1_pixel_reg;
    logic [COL_W-1:0]  s1_col_reg;
    logic              s1_have_reg;
    logic              s1_last_reg;
    border_flags_t     s1_flags_reg;
    logic              s2_valid_reg;
    logic              s2_last_reg;
    border_flags_t     s2_flags_reg;

    logic              s_fire;
    logic              s1_ready;
    logic              s1_adv;
    logic              s2_ready;
    logic              div_ready;
    window_t           win;
    stats_t            stats;

    assign s2_ready = !s2_valid_reg || div_ready;
    assign s1_adv   = s1_valid_reg && s2_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign s_tready = s1_ready;
    assign s_fire   = s_tvalid && s1_ready;
    assign cfg_hit  = cfg_we && ((cfg_index == CFG_WIDTH) || (cfg_index == CFG_HEIGHT) ||
                                 (cfg_index == CFG_TRIM));
    assign pixel    = s_tuser[0] ? '0 : s_tdata[PIX_W-1:0];

    always_comb
    begin
        if (WEFF_W'(width_reg) < WEFF_W'(3))
        begin
            w_eff = WEFF_W'(3);
        end
        else if (WEFF_W'(width_reg) > WEFF_W'(MAX_WIDTH))
        begin
            w_eff = WEFF_W'(MAX_WIDTH);
        end
        else
        begin
            w_eff = WEFF_W'(width_reg);
        end
        if (height_reg < DIM_W'(3))
        begin
            h_eff = DIM_W'(3);
        end
        else if (height_reg > DIM_W'(MAX_HEIGHT))
        begin
            h_eff = DIM_W'(MAX_HEIGHT);
        end
        else
        begin
            h_eff = height_reg;
        end
    end

    // centre sits one row plus one pixel behind the incoming word
    always_comb
    begin
        if (col_reg != '0)
        begin
            cen_row = row_reg - DIM_W'(1);
            cen_col = col_reg - COL_W'(1);
            have    = (row_reg >= DIM_W'(1));
        end
        else
        begin
            cen_row = row_reg - DIM_W'(2);
            cen_col = COL_W'(w_eff - WEFF_W'(1));
            have    = (row_reg >= DIM_W'(2));
        end
        have         = have && (cen_row < h_eff);
        flags.top    = (cen_row == '0);
        flags.bottom = ((cen_row + DIM_W'(1)) >= h_eff);
        flags.left   = (cen_col == '0);
        flags.right  = ((WEFF_W'(cen_col) + WEFF_W'(1)) >= w_eff);
        last         = have && ((cen_row + DIM_W'(1)) == h_eff) &&
                       ((WEFF_W'(cen_col) + WEFF_W'(1)) == w_eff);
        if (last)
        begin
            row_next = '0;
            col_next = '0;
        end
        else if ((WEFF_W'(col_reg) + WEFF_W'(1)) >= w_eff)
        begin
            row_next = row_reg + DIM_W'(1);
            col_next = '0;
        end
        else
        begin
            row_next = row_reg;
            col_next = col_reg + COL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_W'(512);
            height_reg <= DIM_W'(512);
            trim_reg   <= 1'b1;
            row_reg    <= '0;
            col_reg    <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_WIDTH:  width_reg  <= cfg_data;
                CFG_HEIGHT: height_reg <= cfg_data;
                CFG_TRIM:   trim_reg   <= cfg_data[0];
                default:    ;
            endcase
            if (cfg_hit)
            begin
                row_reg <= '0;
                col_reg <= '0;
            end
        end
        else if (s_fire)
        begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= s_tvalid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_adv && s1_have_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            s1_pixel_reg <= pixel;
            s1_col_reg   <= col_reg;
            s1_have_reg  <= have;
            s1_last_reg  <= last;
            s1_flags_reg <= flags;
        end
        if (s1_adv)
        begin
            s2_last_reg  <= s1_last_reg;
            s2_flags_reg <= s1_flags_reg;
        end
    end

    tmf_window #(.MAX_WIDTH(MAX_WIDTH)) u_window (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (s_fire),
        .rd_addr  (col_reg),
        .shift_en (s1_adv),
        .wr_addr  (s1_col_reg),
        .pixel    (s1_pixel_reg),
        .win      (win)
    );

    tmf_reduce u_reduce (
        .win   (win),
        .flags (s2_flags_reg),
        .last  (s2_last_reg),
        .stats (stats)
    );

    tmf_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .trimmed   (trim_reg),
        .in_valid  (s2_valid_reg),
        .in_ready  (div_ready),
        .in_stats  (stats),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_pixel (m_tdata),
        .out_last  (m_tlast)
    );

endmodule

@@ rtl/core/tmf_checker.sv @@
`include "trimmed_mean_3x3_filter_unit_defines.svh"

module tmf_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);

    // hold a stalled result word
    `TMF_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)
    `TMF_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tlast))

    // the pipeline backs up only behind a stalled result
    `TMF_ASSERT_SAME(a_ready_when_drained, !m_tvalid, s_tready)
    `TMF_ASSERT_SAME(a_ready_when_taken, m_tready, s_tready)

endmodule

bind trimmed_mean_3x3_filter_unit tmf_checker u_tmf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
